// ----- design/modular_exponentiation_unit_assert.svh -----
// Assertion macros for the modular exponentiation unit.
`ifndef MODULAR_EXPONENTIATION_UNIT_ASSERT_SVH
`define MODULAR_EXPONENTIATION_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define MEU_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define MEU_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define MEU_ASSERT(label, clk, rst_n, prop)
`define MEU_ASSERT_NR(label, clk, prop)
`endif
`endif

// ----- design/mexp_pkg.sv -----
`default_nettype none
package mexp_pkg;
  localparam int unsigned WordBits = 63;
  localparam int unsigned CntBits = $clog2(WordBits + 1);
  typedef logic [WordBits-1:0] word_t;
  typedef logic [CntBits-1:0] cnt_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_REDUCE, ST_CHECK, ST_MUL, ST_SQR, ST_DONE
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic load;       // capture operands, start base reduction
    logic red_step;   // one restoring-division step on the base
    logic mm_init;    // clear the product register and bit counter
    logic mm_step;    // one shift-and-add step
    logic mm_sel_sq;  // 1: square the base, 0: multiply accumulator by base
    logic wr_acc;     // store product in accumulator
    logic wr_base;    // store product in base, shift exponent
    logic done;       // present the result
  } ctrl_t;

  // Datapath to controller.
  typedef struct packed {
    logic red_last;
    logic mm_last;
    logic exp_zero;
    logic exp_lsb;
    logic mod_zero;
  } stat_t;
endpackage
`default_nettype wire

// ----- design/mexp_ctrl.sv -----
`default_nettype none
module mexp_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  mexp_pkg::stat_t stat_i,
  output mexp_pkg::ctrl_t ctrl_o,
  output logic            busy_o
);
  import mexp_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (start_i) state_d = ST_REDUCE;
      ST_REDUCE: if (stat_i.mod_zero) state_d = ST_DONE;
                 else if (stat_i.red_last) state_d = ST_CHECK;
      ST_CHECK: begin
        if (stat_i.exp_zero) state_d = ST_DONE;
        else if (stat_i.exp_lsb) state_d = ST_MUL;
        else state_d = ST_SQR;
      end
      ST_MUL:    if (stat_i.mm_last) state_d = ST_SQR;
      ST_SQR:    if (stat_i.mm_last) state_d = ST_CHECK;
      ST_DONE:   state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    busy_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        ctrl_o.load = start_i;
      end
      ST_REDUCE: begin
        ctrl_o.red_step = 1'b1;
        ctrl_o.mm_init = 1'b1;
      end
      ST_CHECK: ctrl_o.mm_init = 1'b1;
      ST_MUL: begin
        ctrl_o.mm_step = 1'b1;
        ctrl_o.wr_acc = stat_i.mm_last;
      end
      ST_SQR: begin
        ctrl_o.mm_step = 1'b1;
        ctrl_o.mm_sel_sq = 1'b1;
        ctrl_o.wr_base = stat_i.mm_last;
        ctrl_o.mm_init = stat_i.mm_last;
      end
      ST_DONE: ctrl_o.done = 1'b1;
      default: ctrl_o = '0;
    endcase
  end
endmodule
`default_nettype wire

// ----- design/mexp_datapath.sv -----
`default_nettype none
module mexp_datapath (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mexp_pkg::ctrl_t ctrl_i,
  input  mexp_pkg::word_t modulus_i,
  input  mexp_pkg::word_t base_i,
  input  mexp_pkg::word_t exponent_i,
  output mexp_pkg::stat_t stat_o,
  output mexp_pkg::word_t power_mod_o,
  output logic            power_mod_valid_o
);
  import mexp_pkg::*;

  word_t mod_q, base_q, exp_q, acc_q, prod_q, rem_q, quo_q;
  cnt_t  cnt_q;
  logic  valid_q;
  word_t out_q;

  // Restoring division of the base: quo_q shifts out base bits, rem_q builds remainder.
  logic [WordBits:0] rem_sh, rem_sub;
  // Modular multiply: prod = 2*prod (+ a) mod m, MSB first over b.
  logic [WordBits:0] dbl, dbl_sub, add, add_sub;
  word_t dbl_r, mul_a, mul_b, add_r;
  logic  mul_bit;
  cnt_t  bit_idx;

  always_comb begin
    rem_sh  = {rem_q, quo_q[WordBits-1]};
    rem_sub = rem_sh - {1'b0, mod_q};
    mul_a   = ctrl_i.mm_sel_sq ? base_q : acc_q;
    mul_b   = base_q;
    bit_idx = cnt_t'(WordBits - 1) - cnt_q;
    mul_bit = mul_b[bit_idx[$clog2(WordBits)-1:0]];
    dbl     = {prod_q, 1'b0};
    dbl_sub = dbl - {1'b0, mod_q};
    dbl_r   = dbl_sub[WordBits] ? dbl[WordBits-1:0] : dbl_sub[WordBits-1:0];
    add     = {1'b0, dbl_r} + {1'b0, mul_a};
    add_sub = add - {1'b0, mod_q};
    add_r   = mul_bit ? (add_sub[WordBits] ? add[WordBits-1:0] : add_sub[WordBits-1:0])
                      : dbl_r;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      mod_q <= modulus_i;
      quo_q <= base_i;
      exp_q <= exponent_i;
      rem_q <= '0;
      acc_q <= (modulus_i == word_t'(1)) ? '0 : word_t'(1);
    end
    if (ctrl_i.red_step) begin
      quo_q <= {quo_q[WordBits-2:0], 1'b0};
      rem_q <= rem_sub[WordBits] ? rem_sh[WordBits-1:0] : rem_sub[WordBits-1:0];
    end
    if (ctrl_i.red_step && stat_o.red_last) begin
      base_q <= rem_sub[WordBits] ? rem_sh[WordBits-1:0] : rem_sub[WordBits-1:0];
    end
    if (ctrl_i.wr_acc) acc_q <= add_r;
    if (ctrl_i.wr_base) begin
      base_q <= add_r;
      exp_q  <= exp_q >> 1;
    end
    if (ctrl_i.wr_acc || ctrl_i.wr_base || (ctrl_i.mm_init && !ctrl_i.mm_step)) begin
      prod_q <= '0;
    end else if (ctrl_i.mm_step) begin
      prod_q <= add_r;
    end
    if (ctrl_i.done) out_q <= (mod_q == '0) ? '0 : acc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= ctrl_i.done;
      if (ctrl_i.load || (ctrl_i.mm_init && !ctrl_i.red_step && !ctrl_i.mm_step)
          || ctrl_i.wr_acc || ctrl_i.wr_base) begin
        cnt_q <= '0;
      end else if (ctrl_i.red_step || ctrl_i.mm_step) begin
        cnt_q <= cnt_q + cnt_t'(1);
      end
    end
  end

  always_comb begin
    stat_o.red_last = (cnt_q == cnt_t'(WordBits - 1));
    stat_o.mm_last  = (cnt_q == cnt_t'(WordBits - 1));
    stat_o.exp_zero = (exp_q == '0);
    stat_o.exp_lsb  = exp_q[0];
    stat_o.mod_zero = (mod_q == '0);
  end

  assign power_mod_o       = out_q;
  assign power_mod_valid_o = valid_q;
endmodule
`default_nettype wire

// ----- design/modular_exponentiation_unit.sv -----
// Modular exponentiation unit: power_mod = base ^ exponent mod modulus.
// Usage: write the modulus through the configuration channel
// (cfg_valid_i/cfg_ready_o, data cfg_modulus_i) while the unit is idle.
// The channel is always ready. After reset the modulus is 1.
// A request is accepted at a rising edge with start high and busy low;
// the base and exponent are captured at that edge. busy stays high until
// the result has been presented.
// power_mod_o holds the result; power_mod_valid_o flags it for exactly one
// cycle. The receiver cannot stall; it must take it then.
// Operation: the base is first reduced modulo the modulus by a bit-serial
// restoring division. Then for each exponent bit up to the highest set one,
// a check state is followed by a bit-serial modular multiply into the
// accumulator when the bit is set, and by a bit-serial modular square of the
// base. Both run on the shared shift-and-add multiplier. One request is in
// flight at a time.
// A modulus of zero ends the division early and gives a result of zero; the
// controller goes from REDUCE straight to DONE.
// Reset clears the controller and sets the modulus to 1; operands need none.
`default_nettype none
`include "modular_exponentiation_unit_assert.svh"
module modular_exponentiation_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  mexp_pkg::word_t      base_i,
  input  mexp_pkg::word_t      exponent_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  mexp_pkg::word_t      cfg_modulus_i,
  output mexp_pkg::word_t      power_mod_o,
  output logic                 power_mod_valid_o
);
  import mexp_pkg::*;

  word_t modulus_q;
  ctrl_t ctrl;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  // The modulus register resets to one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= word_t'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      modulus_q <= cfg_modulus_i;
    end
  end

  mexp_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .stat_i (stat),
    .ctrl_o (ctrl),
    .busy_o (busy)
  );

  mexp_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (ctrl),
    .modulus_i        (modulus_q),
    .base_i           (base_i),
    .exponent_i       (exponent_i),
    .stat_o           (stat),
    .power_mod_o      (power_mod_o),
    .power_mod_valid_o(power_mod_valid_o)
  );

  // A result is only flagged at the end of a busy period.
  `MEU_ASSERT(a_valid_busy, clk_i, rst_ni, power_mod_valid_o |-> $past(busy))
  // A result is a single-cycle strobe.
  `MEU_ASSERT(a_valid_pulse, clk_i, rst_ni, power_mod_valid_o |=> !power_mod_valid_o)
  // An accepted request makes the unit busy in the next cycle.
  `MEU_ASSERT(a_start_busy, clk_i, rst_ni, (start && !busy) |=> busy)
endmodule
`default_nettype wire

// ----- test/tb.sv -----
`default_nettype none
module tb;
  import mexp_pkg::*;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  start = 1'b0;
  logic  busy;
  word_t base_i = '0;
  word_t exponent_i = '0;
  logic  cfg_valid_i = 1'b0;
  logic  cfg_ready_o;
  word_t cfg_modulus_i = '0;
  word_t power_mod_o;
  logic  power_mod_valid_o;

  modular_exponentiation_unit u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .base_i(base_i), .exponent_i(exponent_i),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_modulus_i(cfg_modulus_i),
    .power_mod_o(power_mod_o), .power_mod_valid_o(power_mod_valid_o)
  );

  localparam int unsigned StallLimit = 40000;
  localparam word_t       MaxWord = {WordBits{1'b1}};

  typedef struct packed {
    logic  is_cfg;
    word_t base;
    word_t exponent;
    word_t modulus;
  } request_t;

  request_t pending_q[$];
  word_t    expected_q[$];
  word_t    modulus_model;
  int unsigned idle_pct = 38;
  int unsigned quiet_cycles = 0;
  logic        failed = 1'b0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Exact (a * b) mod m by shift and add, with a, b < m.
  function automatic word_t mulmod(word_t a, word_t b, word_t m);
    logic [WordBits:0] r;
    r = '0;
    for (int i = WordBits - 1; i >= 0; i--) begin
      r = r + r;
      if (r >= m) r = r - m;
      if (b[i]) begin
        r = r + a;
        if (r >= m) r = r - m;
      end
    end
    return r[WordBits-1:0];
  endfunction

  function automatic word_t power_mod(word_t b, word_t e, word_t m);
    word_t acc;
    word_t x;
    if (m == '0) return '0;
    x = b % m;
    acc = word_t'(1) % m;
    while (e != '0) begin
      if (e[0]) acc = mulmod(acc, x, m);
      x = mulmod(x, x, m);
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic word_t rand_word();
    return word_t'({$urandom(), $urandom()});
  endfunction

  // Exponents are mostly short to keep the run time down; a few are full width.
  function automatic word_t rand_exp();
    int unsigned n;
    n = ($urandom_range(0, 9) == 0) ? WordBits : $urandom_range(0, 16);
    return (n == 0) ? '0 : rand_word() & (MaxWord >> (WordBits - n));
  endfunction

  task automatic push_op(word_t b, word_t e);
    request_t r;
    r = '{is_cfg: 1'b0, base: b, exponent: e, modulus: '0};
    pending_q.push_back(r);
  endtask

  task automatic push_cfg(word_t m);
    request_t r;
    r = '{is_cfg: 1'b1, base: '0, exponent: '0, modulus: m};
    pending_q.push_back(r);
  endtask

  // Stimulus. A configuration entry is only issued by the driver once the
  // unit is idle and every expected result has come back.
  initial begin
    word_t moduli[6];
    // Directed requests with the reset modulus of one: every result is zero.
    push_op('0, '0);
    push_op(MaxWord, MaxWord);
    push_cfg(MaxWord);
    push_op('0, '0);
    push_op(MaxWord, 63'd1);
    push_op(MaxWord, MaxWord);
    push_op(63'd2, 63'd62);
    push_op(63'd3, '0);
    push_op('0, 63'd5);
    push_cfg(63'd1);
    push_op(63'd7, 63'd3);
    push_cfg(63'd2);
    push_op(63'd3, 63'd4);
    push_op(63'd4, '0);
    push_cfg(63'h7fff_ffff_ffff_ffe7);
    push_op(MaxWord, 63'd2);
    push_op(63'h5555_5555_5555_5555, 63'h2aaa_aaaa_aaaa_aaaa);
    push_cfg('0);
    push_op(63'd9, 63'd9);
    push_op('0, '0);
    moduli = '{63'd97, 63'd1000003, MaxWord, 63'h4000_0000_0000_0000, 63'd3, 63'd0};
    for (int p = 0; p < 6; p++) begin
      push_cfg((p == 5) ? rand_word() | 63'd1 : moduli[p]);
      for (int k = 0; k < 14; k++) begin
        case ($urandom_range(0, 7))
          0: push_op(MaxWord, rand_exp());
          1: push_op(rand_word(), '0);
          default: push_op(rand_word(), rand_exp());
        endcase
      end
    end
    push_cfg(63'd1);
    push_op(rand_word(), rand_exp());
  end

  // Driver.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        expected_q.push_back(power_mod(base_i, exponent_i, modulus_model));
        void'(pending_q.pop_front());
      end
      if (cfg_valid_i && cfg_ready_o) begin
        modulus_model <= cfg_modulus_i;
        void'(pending_q.pop_front());
      end
      if (pending_q.size() != 0 && !(start && !busy) && !(cfg_valid_i && cfg_ready_o)
          && pending_q[0].is_cfg && !busy && !start && expected_q.size() == 0) begin
        cfg_valid_i <= 1'b1;
        cfg_modulus_i <= pending_q[0].modulus;
      end else begin
        cfg_valid_i <= 1'b0;
      end
      if (pending_q.size() != 0 && !(start && !busy) && !(cfg_valid_i && cfg_ready_o)
          && !pending_q[0].is_cfg && !busy && $urandom_range(0, 99) >= idle_pct) begin
        start <= 1'b1;
        base_i <= pending_q[0].base;
        exponent_i <= pending_q[0].exponent;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every result is checked against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && power_mod_valid_o) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, power_mod_o);
        failed = 1'b1;
      end else begin
        if (power_mod_o !== expected_q[0]) begin
          $display("%0t: power_mod expected %h actual %h", $time, expected_q[0],
                   power_mod_o);
          failed = 1'b1;
        end
        void'(expected_q.pop_front());
      end
    end
  end

  // Watchdog on cycles in which no request or result moves.
  always @(posedge clk_i) begin
    if ((start && !busy) || power_mod_valid_o || (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > StallLimit) begin
      $display("modular_exponentiation_unit: mismatch");
      $finish;
    end
  end

  initial begin
    modulus_model = 63'd1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Sender idling schedule: moderate, then heavy, then none.
    wait (pending_q.size() < 60);
    idle_pct = 74;
    wait (pending_q.size() < 30);
    idle_pct = 0;
    wait (pending_q.size() == 0);
    wait (expected_q.size() == 0 && !busy);
    repeat (20) @(posedge clk_i);
    if (!failed && expected_q.size() == 0)
      $display("modular_exponentiation_unit: match");
    else
      $display("modular_exponentiation_unit: mismatch");
    $finish;
  end
endmodule
`default_nettype wire
